// File: hdl/dkp_pkg.sv
// Shared types, constants and layout tables of the DER RSA key stream parser.
package dkp_pkg;

  localparam int LenBits      = 24;
  localparam int NestDepth    = 4;
  localparam int MaxLenOctets = 8;
  localparam int DepthW       = $clog2(NestDepth + 1);
  localparam int IdxW         = $clog2(NestDepth);
  localparam int PhaseW       = 6;
  localparam int PlanLen      = 21;
  localparam int OidLen       = 9;
  localparam int FifoDepth    = 4;

  localparam logic [7:0] TagSeq  = 8'h30;
  localparam logic [7:0] TagInt  = 8'h02;
  localparam logic [7:0] TagBits = 8'h03;
  localparam logic [7:0] TagOcts = 8'h04;
  localparam logic [7:0] TagNull = 8'h05;
  localparam logic [7:0] TagOid  = 8'h06;

  localparam logic [3:0] ErrNone    = 4'd0;
  localparam logic [3:0] ErrTag     = 4'd1;
  localparam logic [3:0] ErrLength  = 4'd2;
  localparam logic [3:0] ErrNest    = 4'd3;
  localparam logic [3:0] ErrInteger = 4'd4;
  localparam logic [3:0] ErrValue   = 4'd5;
  localparam logic [3:0] ErrVersion = 4'd6;
  localparam logic [3:0] ErrAlg     = 4'd7;
  localparam logic [3:0] ErrTrail   = 4'd8;

  localparam logic       CfgKeyKind = 1'b0;
  localparam logic       CfgFormat  = 1'b1;
  localparam logic [1:0] FmtBare    = 2'd1;
  localparam logic [1:0] FmtWrapped = 2'd2;

  typedef enum logic [3:0] {
    K_DONE, K_SEQ, K_INT, K_VER, K_OID, K_NULL, K_BITS, K_OCTS, K_END
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e kind;
    logic [3:0] arg;
  } plan_step_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [2:0] comp_index;
    logic [7:0] comp_byte;
    logic       comp_end;
    logic       key_ok;
    logic [3:0] error_code;
    logic       wrapped_format;
    logic       run_last;
  } res_item_t;

  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } res_push_t;

  function automatic plan_step_t mk(plan_kind_e k, logic [3:0] a);
    plan_step_t s;
    s.kind = k;
    s.arg  = a;
    return s;
  endfunction

  // layout index is {private, wrapped}
  function automatic plan_step_t plan_step(logic [1:0] t, logic [PhaseW-1:0] ph);
    logic [PhaseW-1:0] p;
    plan_step_t s;
    p = (ph < PhaseW'(PlanLen)) ? ph : PhaseW'(PlanLen - 1);
    s = mk(K_DONE, 4'd0);
    unique case (t)
      2'd0: begin
        if (p == 0) s = mk(K_SEQ, 4'd0);
        else if (p == 1) s = mk(K_INT, 4'd0);
        else if (p == 2) s = mk(K_INT, 4'd1);
        else if (p == 3) s = mk(K_END, ErrTrail);
      end
      2'd1: begin
        if (p == 0 || p == 1 || p == 6) s = mk(K_SEQ, 4'd0);
        else if (p == 2) s = mk(K_OID, 4'd0);
        else if (p == 3) s = mk(K_NULL, 4'd0);
        else if (p == 4) s = mk(K_END, ErrAlg);
        else if (p == 5) s = mk(K_BITS, 4'd0);
        else if (p == 7) s = mk(K_INT, 4'd0);
        else if (p == 8) s = mk(K_INT, 4'd1);
        else if (p >= 9 && p <= 11) s = mk(K_END, ErrTrail);
      end
      2'd2: begin
        if (p == 0) s = mk(K_SEQ, 4'd0);
        else if (p == 1) s = mk(K_VER, 4'd0);
        else if (p >= 2 && p <= 9) s = mk(K_INT, 4'(p - 2));
        else if (p == 10) s = mk(K_END, ErrTrail);
      end
      default: begin
        if (p == 0 || p == 2 || p == 7) s = mk(K_SEQ, 4'd0);
        else if (p == 1 || p == 8) s = mk(K_VER, 4'd0);
        else if (p == 3) s = mk(K_OID, 4'd0);
        else if (p == 4) s = mk(K_NULL, 4'd0);
        else if (p == 5) s = mk(K_END, ErrAlg);
        else if (p == 6) s = mk(K_OCTS, 4'd0);
        else if (p >= 9 && p <= 16) s = mk(K_INT, 4'(p - 9));
        else if (p >= 17 && p <= 19) s = mk(K_END, ErrTrail);
      end
    endcase
    return s;
  endfunction

  function automatic logic [7:0] tag_of(plan_kind_e k);
    logic [7:0] t;
    unique case (k)
      K_SEQ:        t = TagSeq;
      K_INT, K_VER: t = TagInt;
      K_OID:        t = TagOid;
      K_NULL:       t = TagNull;
      K_BITS:       t = TagBits;
      K_OCTS:       t = TagOcts;
      default:      t = 8'h00;
    endcase
    return t;
  endfunction

  // rsaEncryption object identifier content
  function automatic logic [7:0] oid_byte(logic [3:0] i);
    logic [7:0] v;
    unique case (i)
      4'd0:    v = 8'h2A;
      4'd1:    v = 8'h86;
      4'd2:    v = 8'h48;
      4'd3:    v = 8'h86;
      4'd4:    v = 8'hF7;
      4'd5:    v = 8'h0D;
      4'd6:    v = 8'h01;
      4'd7:    v = 8'h01;
      4'd8:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/dkp_parser.sv
// Parser state and the per-byte update that produces up to two results.
module dkp_parser import dkp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic      acc_i,
  input  in_item_t  item_i,
  output res_push_t push_o
);

  typedef enum logic [2:0] {ST_TAG, ST_LEN1, ST_LENN, ST_BODY, ST_PAD} stage_e;

  localparam logic [3:0] FStarted = 4'd1;
  localparam logic [3:0] FPending = 4'd2;
  localparam logic [3:0] FMulti   = 4'd4;
  localparam logic [3:0] FNonzero = 4'd8;

  logic               kind_q;
  logic [1:0]         fsel_q;
  stage_e             st_q, st_d;
  logic [PhaseW-1:0]  ph_q, ph_d;
  logic [LenBits-1:0] rem_q [NestDepth];
  logic [LenBits-1:0] rem_d [NestDepth];
  logic [DepthW-1:0]  dep_q, dep_d;
  logic [LenBits-1:0] lacc_q, lacc_d;
  logic [3:0]         lleft_q, lleft_d;
  logic [2:0]         comp_q, comp_d;
  logic [3:0]         fl_q, fl_d;
  logic [7:0]         lm_q, lm_d;
  logic [3:0]         oidp_q, oidp_d;
  logic               fmt_q, fmt_d;
  logic [3:0]         err_q, err_d;
  logic               priv_q, priv_d;
  logic               autop_q, autop_d;
  res_push_t          push;

  always_comb begin
    plan_step_t         s;
    logic [7:0]         b;
    logic               fin;
    logic               hdr;
    logic [LenBits-1:0] hlen;
    logic [IdxW-1:0]    dm1;
    logic               lastb;
    logic               put;
    logic [6:0]         n;
    res_item_t          mag;
    res_item_t          stat;
    logic               mag_v;

    st_d = st_q; ph_d = ph_q; dep_d = dep_q; lacc_d = lacc_q; lleft_d = lleft_q;
    comp_d = comp_q; fl_d = fl_q; lm_d = lm_q; oidp_d = oidp_q; fmt_d = fmt_q;
    err_d = err_q; priv_d = priv_q; autop_d = autop_q;
    for (int i = 0; i < NestDepth; i++) rem_d[i] = rem_q[i];
    b = item_i.in_byte;
    fin = item_i.in_last;
    hdr = 1'b0;
    hlen = '0;
    dm1 = '0;
    lastb = 1'b0;
    put = 1'b0;
    n = b[6:0];
    mag = '0;
    stat = '0;
    mag_v = 1'b0;
    s = plan_step({priv_d, fmt_d}, ph_d);

    if (acc_i) begin
      if (err_d == ErrNone) begin
        if (ph_d == '0 && st_d == ST_TAG && dep_d == '0) begin
          priv_d  = kind_q;
          fmt_d   = (fsel_q == FmtWrapped);
          autop_d = !(fsel_q == FmtBare || fsel_q == FmtWrapped);
        end
        for (int i = 0; i < NestDepth; i++) begin
          if (DepthW'(i) < dep_d && rem_d[i] != '0) rem_d[i] = rem_d[i] - 1'b1;
        end
        dm1 = dep_d[IdxW-1:0] - 1'b1;
        lastb = (dep_d != '0) && (rem_d[dm1] == '0);

        unique case (st_d)
          ST_TAG: begin
            s = plan_step({priv_d, fmt_d}, ph_d);
            if (s.kind == K_DONE) err_d = ErrTrail;
            else if (s.kind == K_END) err_d = s.arg;
            else begin
              // auto mode picks the layout at the first diverging element
              if (autop_d && ph_d == (priv_d ? PhaseW'(2) : PhaseW'(1))) begin
                fmt_d = (b == TagSeq);
                s = plan_step({priv_d, fmt_d}, ph_d);
              end
              if (b != tag_of(s.kind)) err_d = ErrTag;
              else st_d = ST_LEN1;
            end
          end
          ST_LEN1: begin
            if (!b[7]) begin
              hdr = 1'b1;
              hlen = LenBits'(b);
            end else if (n == '0 || n > 7'(MaxLenOctets)) begin
              err_d = ErrLength;
            end else begin
              lleft_d = n[3:0];
              lacc_d = '0;
              st_d = ST_LENN;
            end
          end
          ST_LENN: begin
            if (lacc_d == '0 && b == 8'h00) err_d = ErrLength;
            else if (lacc_d[LenBits-1 -: 8] != 8'h00) err_d = ErrLength;
            else begin
              lacc_d = {lacc_d[LenBits-9:0], b};
              if (lleft_d != 4'd0) lleft_d = lleft_d - 4'd1;
              if (lleft_d == 4'd0) begin
                if (lacc_d < LenBits'(128)) err_d = ErrLength;
                else begin
                  hdr = 1'b1;
                  hlen = lacc_d;
                end
              end
            end
          end
          ST_BODY: begin
            s = plan_step({priv_d, fmt_d}, ph_d);
            if (s.kind == K_VER) begin
              if ((fl_d & FStarted) != '0 || b != 8'h00) err_d = ErrVersion;
              fl_d = fl_d | FStarted;
            end else if (s.kind == K_OID) begin
              if (oidp_d >= 4'(OidLen) || b != oid_byte(oidp_d)) err_d = ErrAlg;
              else oidp_d = oidp_d + 4'd1;
            end else begin
              if ((fl_d & FStarted) == '0) begin
                fl_d = fl_d | FStarted;
                if (b[7]) err_d = ErrInteger;
                else if (b == 8'h00 && !lastb) fl_d = fl_d | FPending;
                else put = 1'b1;
              end else if ((fl_d & FPending) != '0) begin
                fl_d = fl_d & ~FPending;
                if (!b[7]) err_d = ErrInteger;
                else put = 1'b1;
              end else begin
                fl_d = fl_d | FMulti;
                put = 1'b1;
              end
              if (put) begin
                if (b != 8'h00) fl_d = fl_d | FNonzero;
                lm_d = b;
                mag_v = 1'b1;
                mag.comp_index = comp_d;
                mag.comp_byte = b;
                mag.comp_end = lastb;
                mag.run_last = !fin;
              end
            end
          end
          default: begin
            if (b != 8'h00) err_d = ErrValue;
            else begin
              ph_d = ph_d + 1'b1;
              st_d = ST_TAG;
            end
          end
        endcase

        if (hdr) begin
          s = plan_step({priv_d, fmt_d}, ph_d);
          if ((dep_d != '0 && hlen > rem_d[dm1]) || dep_d >= DepthW'(NestDepth))
            err_d = ErrNest;
          else if (s.kind == K_INT && hlen == '0) err_d = ErrInteger;
          else if (s.kind == K_VER && hlen == '0) err_d = ErrVersion;
          else if (s.kind == K_OID && hlen != LenBits'(OidLen)) err_d = ErrAlg;
          else if (s.kind == K_BITS && hlen == '0) err_d = ErrValue;
          else if (s.kind == K_NULL) begin
            if (hlen != '0) err_d = ErrAlg;
            else begin
              ph_d = ph_d + 1'b1;
              st_d = ST_TAG;
            end
          end else begin
            rem_d[dep_d[IdxW-1:0]] = hlen;
            dep_d = dep_d + 1'b1;
            if (s.kind == K_SEQ || s.kind == K_OCTS) begin
              ph_d = ph_d + 1'b1;
              st_d = ST_TAG;
            end else if (s.kind == K_BITS) begin
              st_d = ST_PAD;
            end else begin
              st_d = ST_BODY;
              fl_d = '0;
              oidp_d = '0;
              comp_d = s.arg[2:0];
            end
          end
        end

        // close every element whose byte count has run out
        for (int k = 0; k < NestDepth; k++) begin
          dm1 = dep_d[IdxW-1:0] - 1'b1;
          if (err_d == ErrNone && dep_d != '0 && rem_d[dm1] == '0) begin
            dep_d = dep_d - 1'b1;
            s = plan_step({priv_d, fmt_d}, ph_d);
            if (st_d == ST_BODY) begin
              if (s.kind == K_INT) begin
                if ((fl_d & FNonzero) == '0) err_d = ErrValue;
                else if ((s.arg[2:0] == 3'd0 || s.arg[2:0] == 3'd1 ||
                          s.arg[2:0] == 3'd3 || s.arg[2:0] == 3'd4) &&
                         (!lm_d[0] || ((fl_d & FMulti) == '0 && lm_d == 8'h01)))
                  err_d = ErrValue;
              end
              ph_d = ph_d + 1'b1;
              st_d = ST_TAG;
            end else if (st_d == ST_LEN1 || st_d == ST_LENN) begin
              err_d = ErrLength;
            end else if (s.kind == K_END) begin
              ph_d = ph_d + 1'b1;
            end else begin
              err_d = ErrTag;
            end
          end
        end
      end

      if (fin) begin
        s = plan_step({priv_d, fmt_d}, ph_d);
        if (err_d == ErrNone && s.kind != K_DONE) err_d = ErrLength;
        stat.out_kind = 1'b1;
        stat.key_ok = (err_d == ErrNone);
        stat.error_code = err_d;
        stat.wrapped_format = fmt_d;
        stat.run_last = 1'b1;
        st_d = ST_TAG; ph_d = '0; dep_d = '0; lacc_d = '0; lleft_d = '0;
        comp_d = '0; fl_d = '0; lm_d = '0; oidp_d = '0; fmt_d = 1'b0;
        err_d = ErrNone; priv_d = 1'b0; autop_d = 1'b0;
        for (int i = 0; i < NestDepth; i++) rem_d[i] = '0;
      end
    end

    push = '0;
    if (acc_i) begin
      if (mag_v) begin
        push.first = mag;
        push.second = stat;
        push.count = fin ? 2'd2 : 2'd1;
      end else if (fin) begin
        push.first = stat;
        push.count = 2'd1;
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0; fsel_q <= '0;
      st_q <= ST_TAG; ph_q <= '0; dep_q <= '0; lacc_q <= '0; lleft_q <= '0;
      comp_q <= '0; fl_q <= '0; lm_q <= '0; oidp_q <= '0; fmt_q <= 1'b0;
      err_q <= ErrNone; priv_q <= 1'b0; autop_q <= 1'b0;
      for (int i = 0; i < NestDepth; i++) rem_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgKeyKind) kind_q <= cfg_wdata_i[0];
        else fsel_q <= cfg_wdata_i;
      end
      st_q <= st_d; ph_q <= ph_d; dep_q <= dep_d; lacc_q <= lacc_d; lleft_q <= lleft_d;
      comp_q <= comp_d; fl_q <= fl_d; lm_q <= lm_d; oidp_q <= oidp_d; fmt_q <= fmt_d;
      err_q <= err_d; priv_q <= priv_d; autop_q <= autop_d;
      for (int i = 0; i < NestDepth; i++) rem_q[i] <= rem_d[i];
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= DepthW'(NestDepth)) else $error("open depth above limit");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrNone && !(acc_i && item_i.in_last)) |=> err_q == $past(err_q))
    else $error("first error changed before end of key");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && item_i.in_last) |-> push.count != 2'd0)
    else $error("last byte produced no status");

endmodule

// File: hdl/dkp_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module dkp_res_fifo import dkp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_item_t out_data_o
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  res_item_t       mem_q [FifoDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign pop         = out_valid_o && !out_stall_i;
  // two free entries guarantee space for the worst-case byte
  assign room_o      = (cnt_q <= CntW'(FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wp_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wp_q + 1'b1] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + PtrW'(push_i.count);
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth)) else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> $past(room_o) || room_o)
    else $error("push without room");

endmodule

// File: hdl/der_rsa_key_stream_parser.sv
// Top level of the streaming DER RSA key parser.
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_stall_o  | in_data_i   (in_item_t)
//  out     | out | out_valid_o/out_stall_i| out_data_o  (res_item_t)
//  cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_wdata_i
// One byte per cycle; the parser state updates in the cycle of the transfer.
// Results pass through a 4-entry queue register before they reach out_data_o.
// Input stalls while fewer than two queue entries are free.
// Reset clears parser state and queue pointers, not queue storage; no clearing pass.
module der_rsa_key_stream_parser import dkp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_item_t  out_data_o
);

  logic      room;
  logic      acc;
  res_push_t push;

  assign in_stall_o = !room;
  assign acc = in_valid_i && room;

  dkp_parser u_parser (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .acc_i(acc), .item_i(in_data_i), .push_o(push)
  );

  dkp_res_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .room_o(room),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
